### sv/rle_tilemap_word_decoder_top_assert.svh
// assertion macros for the tile map decoder
`ifndef RLE_TILEMAP_WORD_DECODER_TOP_ASSERT_SVH
`define RLE_TILEMAP_WORD_DECODER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define RLETM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// expression must never be true out of reset
`define RLETM_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define RLETM_ASSERT(lbl, clk, rstn, prop, msg)
`define RLETM_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

### sv/rletm_pkg.sv
package rletm_pkg;

    // decode phase, one-hot
    typedef enum logic [5:0] {
        PH_ROWS = 6'b000001,
        PH_DESC = 6'b000010,
        PH_PAD  = 6'b000100,
        PH_HI   = 6'b001000,
        PH_LO   = 6'b010000,
        PH_CLO  = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        MODE_RUN    = 2'd0,
        MODE_STREAM = 2'd1,
        MODE_COMMON = 2'd2
    } mode_t;

    // handshake controller states, one-hot
    typedef enum logic [1:0] {
        ST_WAIT = 2'b01,
        ST_RUN  = 2'b10
    } ctrl_state_t;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_GAP   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_ODD = 2'd1;

    localparam logic [7:0] LEN_MASK    = 8'b0011_1111;
    localparam logic [7:0] DESC_STREAM = 8'b1000_0000;
    localparam logic [7:0] DESC_COMMON = 8'b1100_0000;

    typedef struct packed {
        logic take;      // process the accepted byte
        logic run_step;  // emit the next word of a run
    } ctrl_cmd_t;

    typedef struct packed {
        logic single;    // accepted byte yields exactly one result
        logic run_start; // accepted byte starts a run of words
        logic run_last;  // the next run word is the final one
    } dp_stat_t;

endpackage

### sv/rletm_ctrl.sv
module rletm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  rletm_pkg::dp_stat_t   stat,
    output rletm_pkg::ctrl_cmd_t  cmd,
    output logic                  run_busy
);

    rletm_pkg::ctrl_state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == rletm_pkg::ST_WAIT) && out_free;
    assign m_valid  = m_valid_reg;
    assign run_busy = (state_reg == rletm_pkg::ST_RUN);

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            rletm_pkg::ST_WAIT: begin
                if (s_valid && s_ready) begin
                    cmd.take = 1'b1;
                    if (stat.single) begin
                        m_valid_next = 1'b1;
                    end else if (stat.run_start) begin
                        state_next = rletm_pkg::ST_RUN;
                    end
                end
            end
            rletm_pkg::ST_RUN: begin
                if (out_free) begin
                    cmd.run_step = 1'b1;
                    m_valid_next = 1'b1;
                    if (stat.run_last) begin
                        state_next = rletm_pkg::ST_WAIT;
                    end
                end
            end
            default: begin
                state_next = rletm_pkg::ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rletm_pkg::ST_WAIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### sv/rletm_dp.sv
module rletm_dp #(
    parameter int OFFSET_BITS = 16,
    parameter int MAX_RUN     = 34
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [7:0]                            stream_byte,
    input  logic                                  cfg_we,
    input  logic [rletm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [7:0]                            cfg_data,
    input  rletm_pkg::ctrl_cmd_t                  cmd,
    output rletm_pkg::dp_stat_t                   stat,
    output logic [15:0]                           tile_word,
    output logic [15:0]                           dest_offset,
    output logic                                  word_valid,
    output logic                                  map_done,
    output logic                                  last_of_run
);

    logic [7:0]             gap_reg;
    logic                   start_odd_reg;
    rletm_pkg::phase_t      phase_reg, phase_next;
    rletm_pkg::mode_t       mode_reg, mode_next;
    logic [7:0]             rows_reg, rows_next;
    logic [5:0]             words_reg, words_next;
    logic [15:0]            partial_reg, partial_next;
    logic                   pos_odd_reg, pos_odd_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;

    logic [15:0]            out_word_reg;
    logic [15:0]            out_off_reg;
    logic                   out_wvalid_reg, out_done_reg, out_last_reg;

    // result built from the accepted byte
    logic [15:0]            res_word;
    logic [OFFSET_BITS-1:0] res_off;
    logic                   res_wvalid, res_done;

    logic [5:0]             len_raw, len_sat, words_dec;
    logic [7:0]             rows_dec;
    logic [15:0]            low_word;
    logic                   pos_t;
    logic [OFFSET_BITS-1:0] off_gap;
    logic [OFFSET_BITS+15:0] res_off_ext, off_ext;

    assign len_raw   = stream_byte[5:0] & rletm_pkg::LEN_MASK[5:0];
    assign len_sat   = (len_raw > 6'(MAX_RUN)) ? 6'(MAX_RUN) : len_raw;
    assign words_dec = (words_reg == 6'd0) ? 6'd0 : words_reg - 6'd1;
    assign rows_dec  = rows_reg - 8'd1;
    assign low_word  = {partial_reg[15:8], stream_byte};
    assign pos_t     = ~pos_odd_reg;
    assign off_gap   = off_reg + OFFSET_BITS'(gap_reg);

    always_comb begin
        phase_next     = phase_reg;
        mode_next      = mode_reg;
        rows_next      = rows_reg;
        words_next     = words_reg;
        partial_next   = partial_reg;
        pos_odd_next   = pos_odd_reg;
        off_next       = off_reg;
        res_word       = 16'd0;
        res_off        = off_reg;
        res_wvalid     = 1'b0;
        res_done       = 1'b0;
        stat.single    = 1'b0;
        stat.run_start = 1'b0;
        stat.run_last  = (words_reg == 6'd1);

        if (cmd.take) begin
            pos_odd_next = pos_t;
            case (phase_reg)
                rletm_pkg::PH_DESC: begin
                    words_next = len_sat;
                    if (stream_byte == 8'd0) begin
                        off_next  = off_gap;
                        rows_next = rows_dec;
                        if (rows_dec == 8'd0) begin
                            stat.single  = 1'b1;
                            res_done     = 1'b1;
                            res_off      = off_gap;
                            phase_next   = rletm_pkg::PH_ROWS;
                            pos_odd_next = start_odd_reg;
                        end
                    end else if (stream_byte < rletm_pkg::DESC_STREAM) begin
                        mode_next  = rletm_pkg::MODE_RUN;
                        phase_next = pos_t ? rletm_pkg::PH_PAD : rletm_pkg::PH_HI;
                    end else if (stream_byte < rletm_pkg::DESC_COMMON) begin
                        mode_next = rletm_pkg::MODE_STREAM;
                        if (pos_t) begin
                            phase_next = rletm_pkg::PH_PAD;
                        end else begin
                            phase_next = (len_sat == 6'd0) ? rletm_pkg::PH_DESC
                                                           : rletm_pkg::PH_HI;
                        end
                    end else begin
                        mode_next  = rletm_pkg::MODE_COMMON;
                        phase_next = rletm_pkg::PH_HI;
                    end
                end
                rletm_pkg::PH_PAD: begin
                    if (mode_reg == rletm_pkg::MODE_STREAM && words_reg == 6'd0) begin
                        phase_next = rletm_pkg::PH_DESC;
                    end else begin
                        phase_next = rletm_pkg::PH_HI;
                    end
                end
                rletm_pkg::PH_HI: begin
                    partial_next = {stream_byte, 8'd0};
                    if (mode_reg == rletm_pkg::MODE_COMMON) begin
                        phase_next = (words_reg == 6'd0) ? rletm_pkg::PH_DESC
                                                         : rletm_pkg::PH_CLO;
                    end else begin
                        phase_next = rletm_pkg::PH_LO;
                    end
                end
                rletm_pkg::PH_LO, rletm_pkg::PH_CLO: begin
                    if (phase_reg == rletm_pkg::PH_LO && mode_reg == rletm_pkg::MODE_RUN) begin
                        // words of a run are emitted by later run steps
                        partial_next   = low_word;
                        stat.run_start = (words_reg != 6'd0);
                        phase_next     = rletm_pkg::PH_DESC;
                    end else begin
                        if (words_reg != 6'd0) begin
                            stat.single = 1'b1;
                            res_word    = low_word;
                            res_wvalid  = 1'b1;
                            off_next    = off_reg + OFFSET_BITS'(2);
                        end
                        words_next = words_dec;
                        if (words_dec == 6'd0) begin
                            phase_next = rletm_pkg::PH_DESC;
                        end else begin
                            phase_next = phase_reg;
                        end
                        if (phase_reg == rletm_pkg::PH_LO && words_dec != 6'd0) begin
                            phase_next = rletm_pkg::PH_HI;
                        end
                    end
                end
                default: begin
                    // row count byte opens a new map
                    off_next  = '0;
                    rows_next = stream_byte;
                    res_off   = '0;
                    if (stream_byte == 8'd0) begin
                        stat.single  = 1'b1;
                        res_done     = 1'b1;
                        phase_next   = rletm_pkg::PH_ROWS;
                        pos_odd_next = start_odd_reg;
                    end else begin
                        phase_next = rletm_pkg::PH_DESC;
                    end
                end
            endcase
        end else if (cmd.run_step) begin
            words_next = words_dec;
            off_next   = off_reg + OFFSET_BITS'(2);
        end

        if (cfg_we && cfg_index == rletm_pkg::CFG_START_ODD
            && phase_reg == rletm_pkg::PH_ROWS) begin
            pos_odd_next = cfg_data[0];
        end
    end

    assign res_off_ext = {16'd0, res_off};
    assign off_ext     = {16'd0, off_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg       <= 8'd0;
            start_odd_reg <= 1'b0;
            phase_reg     <= rletm_pkg::PH_ROWS;
            mode_reg      <= rletm_pkg::MODE_RUN;
            rows_reg      <= 8'd0;
            words_reg     <= 6'd0;
            partial_reg   <= 16'd0;
            pos_odd_reg   <= 1'b0;
            off_reg       <= '0;
        end else begin
            if (cfg_we && cfg_index == rletm_pkg::CFG_ROW_GAP) begin
                gap_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == rletm_pkg::CFG_START_ODD) begin
                start_odd_reg <= cfg_data[0];
            end
            phase_reg   <= phase_next;
            mode_reg    <= mode_next;
            rows_reg    <= rows_next;
            words_reg   <= words_next;
            partial_reg <= partial_next;
            pos_odd_reg <= pos_odd_next;
            off_reg     <= off_next;
        end
    end

    // output payload, loaded with each result
    always_ff @(posedge aclk) begin
        if (cmd.take && stat.single) begin
            out_word_reg   <= res_word;
            out_off_reg    <= res_off_ext[15:0];
            out_wvalid_reg <= res_wvalid;
            out_done_reg   <= res_done;
            out_last_reg   <= 1'b1;
        end else if (cmd.run_step) begin
            out_word_reg   <= partial_reg;
            out_off_reg    <= off_ext[15:0];
            out_wvalid_reg <= 1'b1;
            out_done_reg   <= 1'b0;
            out_last_reg   <= (words_reg == 6'd1);
        end
    end

    assign tile_word   = out_word_reg;
    assign dest_offset = out_off_reg;
    assign word_valid  = out_wvalid_reg;
    assign map_done    = out_done_reg;
    assign last_of_run = out_last_reg;

endmodule

### sv/rle_tilemap_word_decoder_top.sv
// a byte's result item is registered as it is accepted; run words come from the run state
// throughput: one input byte per cycle while the output side keeps up and no run is busy
// the low byte of a run holds off input until all n words of the run are emitted,
// as the run engine emits one word per cycle with a free output slot
// reset: aresetn synchronous active low, clears decoder state, config registers and valid
`include "rle_tilemap_word_decoder_top_assert.svh"

module rle_tilemap_word_decoder_top #(
    parameter int OFFSET_BITS = 16,
    parameter int MAX_RUN     = 34
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // compressed byte stream in
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_stream_byte,
    // decoded words out
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [15:0]                       m_tile_word,
    output logic [15:0]                       m_dest_offset,
    output logic                              m_word_valid,
    output logic                              m_map_done,
    output logic                              m_last_of_run,
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rletm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                        cfg_data
);

    rletm_pkg::ctrl_cmd_t cmd;
    rletm_pkg::dp_stat_t  stat;
    logic                 run_busy;
    logic                 cfg_we;

    // register writes are always taken; only legal while idle
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // handshake controller: byte accept and run word sequencing
    rletm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stat     (stat),
        .cmd      (cmd),
        .run_busy (run_busy)
    );

    // decode state, offsets, config registers and the output register
    rletm_dp #(
        .OFFSET_BITS (OFFSET_BITS),
        .MAX_RUN     (MAX_RUN)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .stream_byte (s_stream_byte),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .stat        (stat),
        .tile_word   (m_tile_word),
        .dest_offset (m_dest_offset),
        .word_valid  (m_word_valid),
        .map_done    (m_map_done),
        .last_of_run (m_last_of_run)
    );

    // no byte taken while a run is being emitted
    `RLETM_NEVER(a_no_accept_in_run, aclk, aresetn, s_valid && s_ready && run_busy, "byte accepted during run")
    // a done marker carries no word and closes its byte
    `RLETM_ASSERT(a_done_shape, aclk, aresetn, m_valid && m_map_done |-> !m_word_valid && m_last_of_run, "bad done item")
    // run start puts the controller into the run state next cycle
    `RLETM_ASSERT(a_run_follows, aclk, aresetn, cmd.take && stat.run_start |=> run_busy, "run not started")
    // a run step always loads a word item
    `RLETM_ASSERT(a_run_word, aclk, aresetn, cmd.run_step |=> m_valid && m_word_valid, "run word missing")

endmodule
